// ----- rtl/fdlp_pkg.sv -----
package fdlp_pkg;

    localparam int DEF_SCREEN_WIDTH  = 160;
    localparam int DEF_SCREEN_HEIGHT = 100;

    // Q.14 accumulator and pixel index widths cover a 1024 x 1024 screen
    localparam int ACC_W   = 27;
    localparam int PIX_W   = 11;
    localparam int FRAC_SH = 14;
    localparam int COUNT_MAX = 16383;

    typedef logic [1:0]         t_op;
    typedef logic signed [15:0] t_coord;
    typedef logic [2:0]         t_color;
    typedef logic [7:0]         t_col;
    typedef logic [6:0]         t_row;
    typedef logic [13:0]        t_count;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] idx;
    } t_pix;

    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_POINT = 2'd1;
    localparam t_op OP_LINE  = 2'd2;
    localparam t_op OP_READ  = 2'd3;

endpackage

// ----- rtl/fdlp_ifs.sv -----
interface fdlp_cmd_if;
    import fdlp_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;
    t_color paint_color;
    t_col   read_col;
    t_row   read_row;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end,
               paint_color, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end,
               paint_color, read_col, read_row,
        output ready
    );
endinterface

interface fdlp_res_if;
    import fdlp_pkg::*;

    logic   valid;
    logic   ready;
    t_color read_color;
    t_count pixels_written;

    modport source (output valid, read_color, pixels_written, input ready);
    modport sink (input valid, read_color, pixels_written, output ready);
endinterface

// ----- rtl/fdlp_ram.sv -----
module fdlp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/framebuffer_dda_line_plotter.sv -----
// Frame buffer of 3-bit color codes, SCREEN_WIDTH x SCREEN_HEIGHT, in one RAM with one
// write and one registered read port. One command is taken at a time; a command is
// accepted only while the block is idle, and its single result waits in an output
// register. After reset the block sweeps all SCREEN_WIDTH*SCREEN_HEIGHT RAM words (16000
// at the default size) to zero before it takes a command. A clear writes one RAM word
// per cycle; a point plots one pixel; a read addresses the RAM, then takes its registered
// data; a line plots (S>>6)+1 pixels, where S = max(|dx|,|dy|) in Q10.6, after two
// increment divisions when S is nonzero, 15 quotient bits each, through one shared
// subtract-and-compare unit; the plot steps are set by the single RAM write port, one
// pixel per cycle.
module framebuffer_dda_line_plotter #(
    parameter int SCREEN_WIDTH  = fdlp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = fdlp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdlp_cmd_if.sink    i_cmd,
    fdlp_res_if.source  o_res
);
    import fdlp_pkg::*;

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLEAR_COUNT = (DEPTH > COUNT_MAX) ? COUNT_MAX : DEPTH;
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_LSETUP = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_PLOT   = 3'd4;
    localparam logic [2:0] S_RADDR  = 3'd5;
    localparam logic [2:0] S_RWAIT  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    function automatic logic signed [ACC_W-1:0] to_acc(input t_coord c);
        return {{(ACC_W - 24){c[15]}}, c, 8'b0};
    endfunction

    // trunc(v), minus one when v > 0, with the window check on one axis
    function automatic t_pix pix_map(input logic signed [ACC_W-1:0] v,
                                     input logic [ACC_W-FRAC_SH-1:0] lim);
        t_pix p;
        logic [ACC_W-FRAC_SH-1:0] t;
        t = v[ACC_W-1:FRAC_SH];
        if (!v[ACC_W-1] && v != '0) begin
            p.ok  = (t != '0) && (t <= lim);
            p.idx = PIX_W'(t - 1'b1);
        end else begin
            p.ok  = (v > -(ACC_W'(1) <<< FRAC_SH));
            p.idx = '0;
        end
        return p;
    endfunction

    logic [2:0]              r_state;
    logic                    r_report;
    t_color                  r_color;
    t_coord                  r_x0, r_y0, r_x1, r_y1;
    t_col                    r_rd_col;
    t_row                    r_rd_row;
    logic [16:0]             r_s, r_ady;
    logic                    r_sx, r_sy;
    logic [17:0]             r_rem;
    logic [14:0]             r_quo;
    logic [3:0]              r_bit;
    logic                    r_div_y;
    logic signed [15:0]      r_ix, r_iy;
    logic signed [ACC_W-1:0] r_xq, r_yq;
    logic [PIX_W-1:0]        r_left;
    t_count                  r_count;
    logic                    r_wr_valid;
    logic [PIX_W-1:0]        r_wr_x, r_wr_y;
    logic [ADDR_W-1:0]       r_sweep;
    logic                    r_rd_ok;
    t_color                  r_res_color;
    logic                    r_out_valid;
    t_color                  r_out_color;
    t_count                  r_out_count;

    logic signed [16:0] dx_w, dy_w;
    logic [16:0]        adx_w, ady_w, s_w;
    logic               div_ge;
    logic [17:0]        rem_next;
    logic [14:0]        quo_next;
    logic signed [15:0] inc_w;
    t_pix               px_w, py_w;
    logic [PIX_W-1:0]   mul_row, mul_col;
    logic [ADDR_W-1:0]  mul_addr;
    logic               rd_in_win;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_color             ram_rdata;

    // line setup
    always_comb begin
        dx_w  = {r_x1[15], r_x1} - {r_x0[15], r_x0};
        dy_w  = {r_y1[15], r_y1} - {r_y0[15], r_y0};
        adx_w = dx_w[16] ? 17'(-dx_w) : 17'(dx_w);
        ady_w = dy_w[16] ? 17'(-dy_w) : 17'(dy_w);
        s_w   = (adx_w >= ady_w) ? adx_w : ady_w;
    end

    // shared restoring divider: one quotient bit of |d| * 2^14 / S per cycle
    always_comb begin
        div_ge   = (r_rem >= {1'b0, r_s});
        rem_next = {(div_ge ? 17'(r_rem - {1'b0, r_s}) : r_rem[16:0]), 1'b0};
        quo_next = {r_quo[13:0], div_ge};
        inc_w    = (r_div_y ? r_sy : r_sx) ? -$signed({1'b0, quo_next})
                                           : $signed({1'b0, quo_next});
    end

    always_comb begin
        px_w = pix_map(r_xq, (ACC_W - FRAC_SH)'(SCREEN_WIDTH));
        py_w = pix_map(r_yq, (ACC_W - FRAC_SH)'(SCREEN_HEIGHT));
    end

    // one address multiplier, shared by the read and the pixel write
    always_comb begin
        if (r_state == S_RADDR) begin
            mul_row = PIX_W'(r_rd_row);
            mul_col = PIX_W'(r_rd_col);
        end else begin
            mul_row = r_wr_y;
            mul_col = r_wr_x;
        end
        mul_addr  = ADDR_W'(32'(mul_row) * 32'(SCREEN_WIDTH) + 32'(mul_col));
        rd_in_win = (PIX_W'(r_rd_col) < PIX_W'(SCREEN_WIDTH))
                 && (PIX_W'(r_rd_row) < PIX_W'(SCREEN_HEIGHT));
        ram_we    = (r_state == S_CLEAR) || r_wr_valid;
        ram_waddr = (r_state == S_CLEAR) ? r_sweep : mul_addr;
    end

    fdlp_ram #(
        .WIDTH ($bits(t_color)),
        .DEPTH (DEPTH)
    ) u_fdlp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_color),
        .i_raddr (mul_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_report    <= 1'b0;
            r_color     <= '0;
            r_sweep     <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_valid  <= (r_state == S_PLOT) && px_w.ok && py_w.ok;
            // hold a stalled beat, load a new one from S_DONE
            r_out_valid <= (r_state == S_DONE) || (r_out_valid && !o_res.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_color     <= i_cmd.paint_color;
                        r_x0        <= i_cmd.x_start;
                        r_y0        <= i_cmd.y_start;
                        r_x1        <= i_cmd.x_end;
                        r_y1        <= i_cmd.y_end;
                        r_rd_col    <= i_cmd.read_col;
                        r_rd_row    <= i_cmd.read_row;
                        r_count     <= '0;
                        r_res_color <= '0;
                        unique case (i_cmd.operation)
                            OP_CLEAR: begin
                                r_sweep  <= '0;
                                r_report <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            OP_POINT: begin
                                r_xq    <= to_acc(i_cmd.x_start);
                                r_yq    <= to_acc(i_cmd.y_start);
                                r_ix    <= '0;
                                r_iy    <= '0;
                                r_left  <= PIX_W'(1);
                                r_state <= S_PLOT;
                            end
                            OP_LINE: begin
                                r_state <= S_LSETUP;
                            end
                            OP_READ: begin
                                r_state <= S_RADDR;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (r_sweep == SWEEP_LAST) begin
                        r_count <= t_count'(CLEAR_COUNT);
                        r_state <= r_report ? S_DONE : S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_LSETUP: begin
                    r_s     <= s_w;
                    r_ady   <= ady_w;
                    r_sx    <= dx_w[16];
                    r_sy    <= dy_w[16];
                    r_xq    <= to_acc(r_x0);
                    r_yq    <= to_acc(r_y0);
                    r_ix    <= '0;
                    r_iy    <= '0;
                    r_left  <= s_w[16:6] + 1'b1;
                    r_rem   <= {1'b0, adx_w};
                    r_quo   <= '0;
                    r_bit   <= 4'd14;
                    r_div_y <= 1'b0;
                    r_state <= (s_w == '0) ? S_PLOT : S_DIV;
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        if (!r_div_y) begin
                            // x done, restart the unit on |dy|
                            r_ix    <= inc_w;
                            r_rem   <= {1'b0, r_ady};
                            r_quo   <= '0;
                            r_bit   <= 4'd14;
                            r_div_y <= 1'b1;
                        end else begin
                            r_iy    <= inc_w;
                            r_state <= S_PLOT;
                        end
                    end else begin
                        r_rem <= rem_next;
                        r_quo <= quo_next;
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_PLOT: begin
                    r_wr_x     <= px_w.idx;
                    r_wr_y     <= py_w.idx;
                    if (px_w.ok && py_w.ok) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_xq   <= r_xq + ACC_W'(r_ix);
                    r_yq   <= r_yq + ACC_W'(r_iy);
                    r_left <= r_left - 1'b1;
                    // the last write lands while the result is posted
                    if (r_left == PIX_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_RADDR: begin
                    r_rd_ok <= rd_in_win;
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_res_color <= r_rd_ok ? ram_rdata : '0;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_color <= r_res_color;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.read_color     = r_out_color;
    assign o_res.pixels_written = r_out_count;

endmodule

// ----- rtl/fdlp_checker.sv -----
module fdlp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input fdlp_pkg::t_color i_res_color,
    input fdlp_pkg::t_count i_res_count
);
    // hold a stalled result beat
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_color) && $stable(i_res_count))
        else $error("result payload changed while stalled");

    // a read reports no writes, so a nonzero color means a zero count
    a_color_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_color != '0 |-> i_res_count == '0)
        else $error("result carries both a color and a write count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while one is in progress");

    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_cmd_ready)
        else $error("command port open during the reset sweep");
endmodule

bind framebuffer_dda_line_plotter fdlp_checker u_fdlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_color (o_res.read_color),
    .i_res_count (o_res.pixels_written)
);

// ----- tb/framebuffer_dda_line_plotter_tb.sv -----
module framebuffer_dda_line_plotter_tb;
    import fdlp_pkg::*;

    localparam int SCREEN_W     = DEF_SCREEN_WIDTH;
    localparam int SCREEN_H     = DEF_SCREEN_HEIGHT;
    localparam int FRAME_PIXELS = SCREEN_W * SCREEN_H;
    localparam int RANDOM_CMDS  = 1125;
    localparam int GAP_MAX      = 80;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_COUNT   = 2;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        t_op    op;
        t_coord xs;
        t_coord ys;
        t_coord xe;
        t_coord ye;
        t_color color;
        t_col   col;
        t_row   row;
    } plot_cmd_t;

    typedef struct {
        t_color read_color;
        t_count pixels_written;
    } pixel_report_t;

    logic clk;
    logic rst_n;

    fdlp_cmd_if cmd_bus();
    fdlp_res_if res_bus();

    framebuffer_dda_line_plotter uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    t_color        shadow_frame [FRAME_PIXELS];
    plot_cmd_t     cmd_backlog [$];
    pixel_report_t pending_reports [$];
    plot_cmd_t     live_cmd;
    pixel_report_t rx_want;

    int unsigned cmds_accepted;
    int unsigned total_cmds;
    int unsigned error_count;
    int unsigned tx_gap;
    int unsigned tx_next_gap;
    int unsigned rx_gap;
    int unsigned rx_next_gap;
    int unsigned hold_left;
    int unsigned holds_started;
    bit          tx_calm;
    bit          rx_calm;
    longint      cycle_count;
    longint      cycle_budget;
    longint      cycle_limit;

    // ---------------------------------------------------------------
    // Frame buffer predictor
    // ---------------------------------------------------------------

    // trunc(v), minus one when v is positive
    function automatic longint pixel_of(longint v);
        if (v > 0)
            return (v >>> FRAC_SH) - 1;
        return -((-v) >>> FRAC_SH);
    endfunction

    function automatic int unsigned paint_dot(longint xq, longint yq, t_color c);
        longint px;
        longint py;
        px = pixel_of(xq);
        py = pixel_of(yq);
        if (px < 0 || px >= SCREEN_W || py < 0 || py >= SCREEN_H)
            return 0;
        shadow_frame[int'(py * SCREEN_W + px)] = c;
        return 1;
    endfunction

    function automatic longint line_span(plot_cmd_t c);
        longint adx;
        longint ady;
        adx = longint'(c.xe) - longint'(c.xs);
        ady = longint'(c.ye) - longint'(c.ys);
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        return (adx >= ady) ? adx : ady;
    endfunction

    // Q1.14 per-step increment, truncated toward zero
    function automatic longint dda_step(longint d, longint span);
        longint q;
        q = ((d < 0 ? -d : d) * 16384) / span;
        return (d < 0) ? -q : q;
    endfunction

    function automatic pixel_report_t rasterize_cmd(plot_cmd_t c);
        pixel_report_t r;
        longint        span;
        longint        step_x;
        longint        step_y;
        longint        xq;
        longint        yq;
        longint        dots;
        int unsigned   hits;
        r.read_color = '0;
        hits = 0;
        case (c.op)
            OP_CLEAR: begin
                foreach (shadow_frame[i]) shadow_frame[i] = c.color;
                hits = FRAME_PIXELS;
            end
            OP_POINT: begin
                hits = paint_dot(longint'(c.xs) * 256, longint'(c.ys) * 256, c.color);
            end
            OP_LINE: begin
                span   = line_span(c);
                step_x = 0;
                step_y = 0;
                if (span != 0) begin
                    step_x = dda_step(longint'(c.xe) - longint'(c.xs), span);
                    step_y = dda_step(longint'(c.ye) - longint'(c.ys), span);
                end
                xq   = longint'(c.xs) * 256;
                yq   = longint'(c.ys) * 256;
                dots = (span >> 6) + 1;
                for (longint i = 0; i < dots; i++) begin
                    hits += paint_dot(xq, yq, c.color);
                    xq += step_x;
                    yq += step_y;
                end
            end
            default: begin
                if (c.col < SCREEN_W && c.row < SCREEN_H)
                    r.read_color = shadow_frame[int'(c.row) * SCREEN_W + int'(c.col)];
            end
        endcase
        r.pixels_written = t_count'(hits > COUNT_MAX ? COUNT_MAX : hits);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic longint busy_cycles(plot_cmd_t c);
        case (c.op)
            OP_CLEAR: return FRAME_PIXELS + 1;
            OP_POINT: return 3;
            OP_LINE:  return 34 + (line_span(c) >> 6);
            default:  return 4;
        endcase
    endfunction

    function automatic plot_cmd_t mk_cmd(t_op op, int xs, int ys, int xe, int ye,
                                         int color, int col, int row);
        plot_cmd_t c;
        c.op    = op;
        c.xs    = t_coord'(xs);
        c.ys    = t_coord'(ys);
        c.xe    = t_coord'(xe);
        c.ye    = t_coord'(ye);
        c.color = t_color'(color);
        c.col   = t_col'(col);
        c.row   = t_row'(row);
        return c;
    endfunction

    function automatic void stage_cmd(plot_cmd_t c);
        cmd_backlog.push_back(c);
        total_cmds++;
        cycle_budget += busy_cycles(c) + 2 * GAP_MAX + 8;
    endfunction

    // Q10.6 coordinate from four units before to four units past the window along an axis of the given size
    function automatic t_coord near_window(int units);
        return t_coord'(int'($urandom_range(0, (units + 8) * 64)) - 4 * 64);
    endfunction

    function automatic t_coord any_coord();
        return t_coord'($urandom_range(0, 16'hFFFF));
    endfunction

    // mostly short, now and then long; zero throughout a calm stretch
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, GAP_MAX);
    endfunction

    function automatic void flag_error(string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset and stimulus
    // ---------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        plot_cmd_t   c;
        int unsigned pick;
        int unsigned shape;

        rst_n               = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.operation   = OP_CLEAR;
        cmd_bus.x_start     = '0;
        cmd_bus.y_start     = '0;
        cmd_bus.x_end       = '0;
        cmd_bus.y_end       = '0;
        cmd_bus.paint_color = '0;
        cmd_bus.read_col    = '0;
        cmd_bus.read_row    = '0;
        res_bus.ready       = 1'b0;
        total_cmds          = 0;
        cycle_budget        = FRAME_PIXELS + HOLD_COUNT * HOLD_CYCLES;
        foreach (shadow_frame[i]) shadow_frame[i] = '0;

        // directed: corners, rounding around zero, window edges, extremes
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 255, 127));
        stage_cmd(mk_cmd(OP_POINT, -32, -32, 0, 0, 5, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        stage_cmd(mk_cmd(OP_POINT, 32, 32, 0, 0, 3, 0, 0));
        stage_cmd(mk_cmd(OP_POINT, 10240, 6400, 0, 0, 7, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 159, 99));
        stage_cmd(mk_cmd(OP_POINT, 32767, -32768, 0, 0, 1, 0, 0));
        stage_cmd(mk_cmd(OP_POINT, -32768, 32767, 0, 0, 2, 0, 0));
        // zero-length line plots its start only
        stage_cmd(mk_cmd(OP_LINE, 640, 640, 640, 640, 2, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 9, 9));
        // x = 1.0 and x = 0.0 both land on column 0
        stage_cmd(mk_cmd(OP_LINE, 64, 0, -64, 0, 4, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        stage_cmd(mk_cmd(OP_LINE, 0, 320, 10240, 320, 6, 0, 0));
        stage_cmd(mk_cmd(OP_LINE, 9632, 6336, 1296, 0, 1, 0, 0));
        stage_cmd(mk_cmd(OP_LINE, -32768, -32768, 32767, 32767, 3, 0, 0));
        stage_cmd(mk_cmd(OP_LINE, 32767, -32768, -32768, 32767, 5, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 80, 50));
        stage_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 6, 0, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 80, 50));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 160, 0));
        stage_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 100));
        stage_cmd(mk_cmd(OP_POINT, 64, 64, 0, 0, 0, 0, 0));
        stage_cmd(mk_cmd(OP_LINE, 6400, 0, 0, 6400, 7, 0, 0));
        stage_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        // random: every field starts fully random, then the operation shapes it
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            c = mk_cmd(OP_READ, any_coord(), any_coord(), any_coord(), any_coord(),
                       $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 127));
            pick = $urandom_range(0, 999);
            if (pick < 20) begin
                c.op = OP_CLEAR;
            end else if (pick < 270) begin
                c.op = OP_POINT;
                if ($urandom_range(0, 99) < 85) begin
                    c.xs = near_window(SCREEN_W);
                    c.ys = near_window(SCREEN_H);
                end
            end else if (pick < 670) begin
                c.op  = OP_LINE;
                shape = $urandom_range(0, 99);
                if (shape < 55) begin
                    c.xs = near_window(SCREEN_W);
                    c.ys = near_window(SCREEN_H);
                    c.xe = t_coord'(int'(c.xs) + int'($urandom_range(0, 2560)) - 1280);
                    c.ye = t_coord'(int'(c.ys) + int'($urandom_range(0, 2560)) - 1280);
                end else if (shape < 80) begin
                    c.xs = near_window(SCREEN_W);
                    c.ys = near_window(SCREEN_H);
                    c.xe = near_window(SCREEN_W);
                    c.ye = near_window(SCREEN_H);
                end else if (shape >= 92) begin
                    if (shape < 96) begin
                        c.xs = near_window(SCREEN_W);
                        c.ys = near_window(SCREEN_H);
                    end
                    c.xe = c.xs;
                    c.ye = c.ys;
                end
            end else if ($urandom_range(0, 99) < 88) begin
                c.col = t_col'($urandom_range(0, SCREEN_W - 1));
                c.row = t_row'($urandom_range(0, SCREEN_H - 1));
            end
            stage_cmd(c);
        end

        cycle_limit = 4 * cycle_budget + 20000;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted < total_cmds || pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("framebuffer_dda_line_plotter regression: pass");
        else
            $display("framebuffer_dda_line_plotter regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Command driver
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_bus.valid <= 1'b0;
            tx_gap        <= 0;
            cmds_accepted <= 0;
        end else begin
            tx_next_gap = tx_gap;
            if (cmd_bus.valid && cmd_bus.ready) begin
                pending_reports.push_back(rasterize_cmd(live_cmd));
                cmds_accepted <= cmds_accepted + 1;
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                tx_next_gap = pick_gap(tx_calm);
            end
            if (cmd_bus.valid && !cmd_bus.ready) begin
                // hold the beat until it is taken
            end else if (tx_next_gap > 0) begin
                tx_gap        <= tx_next_gap - 1;
                cmd_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                live_cmd = cmd_backlog.pop_front();
                cmd_bus.operation   <= live_cmd.op;
                cmd_bus.x_start     <= live_cmd.xs;
                cmd_bus.y_start     <= live_cmd.ys;
                cmd_bus.x_end       <= live_cmd.xe;
                cmd_bus.y_end       <= live_cmd.ye;
                cmd_bus.paint_color <= live_cmd.color;
                cmd_bus.read_col    <= live_cmd.col;
                cmd_bus.read_row    <= live_cmd.row;
                cmd_bus.valid       <= 1'b1;
                tx_gap              <= 0;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Long receiver hold-off: stall results so the block backs up
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left     <= 0;
            holds_started <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_started < HOLD_COUNT &&
                     cmds_accepted >= 300 + 500 * holds_started) begin
            hold_left     <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            rx_gap        <= 0;
        end else begin
            rx_next_gap = (rx_gap > 0) ? rx_gap - 1 : 0;
            if (res_bus.valid && res_bus.ready) begin
                if (pending_reports.size() == 0) begin
                    flag_error($sformatf("unexpected result beat: read_color %0d pixels_written %0d",
                                         res_bus.read_color, res_bus.pixels_written));
                end else begin
                    rx_want = pending_reports.pop_front();
                    if (res_bus.read_color !== rx_want.read_color)
                        flag_error($sformatf("read_color mismatch: expected %0d, got %0d",
                                             rx_want.read_color, res_bus.read_color));
                    if (res_bus.pixels_written !== rx_want.pixels_written)
                        flag_error($sformatf("pixels_written mismatch: expected %0d, got %0d",
                                             rx_want.pixels_written, res_bus.pixels_written));
                end
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_next_gap = pick_gap(rx_calm);
            end
            rx_gap        <= rx_next_gap;
            res_bus.ready <= (rx_next_gap == 0) && (hold_left == 0);
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("framebuffer_dda_line_plotter regression: fail");
            $finish;
        end
    end

endmodule
